/* hdl/ucc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and calendar tables for the Unix time / calendar converter.
package ucc_pkg;

    // Stream payload widths (whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;

    // Operation codes carried on s_axis_tuser
    localparam logic OP_DATE_TO_SEC = 1'b0;
    localparam logic OP_SEC_TO_DATE = 1'b1;

    // Calendar constants
    localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
    localparam logic [11:0] LEAP_BASE_YEAR = 12'd1969;
    localparam logic [31:0] DAYS_PER_YEAR  = 32'd365;
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN   = 17'd60;
    localparam logic [16:0] DAYS_PER_CYCLE = 17'd1461;
    localparam logic [10:0] NORM_YEAR_DAYS = 11'd365;
    localparam logic [10:0] LEAP_YEAR_DAYS = 11'd366;

    // Year index inside a four-year cycle (cycle starts at 1970)
    localparam logic [1:0] LEAP_YEAR_IDX = 2'd2;
    localparam logic [1:0] LAST_YEAR_IDX = 2'd3;
    localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

    // Serial divider sizing
    localparam int DIV_REM_W  = 17;
    localparam int DIV_BITS_W = 16;
    localparam int DIV_CNT_W  = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR_MAC,
        ST_TIME_MAC,
        ST_DIV_DAY,
        ST_DIV_HOUR,
        ST_DIV_MIN,
        ST_DIV_CYC,
        ST_WALK_YEAR,
        ST_WALK_MONTH,
        ST_DONE
    } ucc_state_t;

    // Request into the serial divider: dividend pre-split into a starting
    // remainder (must be below the divisor) and the bits still to shift in
    typedef struct packed {
        logic                  start;
        logic [DIV_REM_W-1:0]  rem_init;
        logic [DIV_BITS_W-1:0] bits;
        logic [DIV_REM_W-1:0]  divisor;
        logic [DIV_CNT_W-1:0]  count;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic qbit_valid;
        logic qbit;
    } div_stat_t;

    // Days before the first of a month in a common year, month index 0..11
    function automatic logic [8:0] cum_days(input logic [3:0] month_idx);
        logic [8:0] d;
        case (month_idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of a month, index 0..11; February gets 29 in a leap year
    function automatic logic [4:0] days_in_month(input logic [3:0] month_idx, input logic leap);
        logic [4:0] d;
        case (month_idx)
            4'd1:    d = leap ? 5'd29 : 5'd28;
            4'd3:    d = 5'd30;
            4'd5:    d = 5'd30;
            4'd8:    d = 5'd30;
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

/* hdl/unix_time_calendar_converter_unit.sv */
`timescale 1ns / 1ps
// Top level: Unix seconds <-> calendar date/time converter with stream ports.
//
//  channel | dir | tdata / tuser contents
//  --------+-----+--------------------------------------------------------------
//  s_axis  | in  | tuser: operation; tdata: seconds, year, month, day, hour, min, sec
//  m_axis  | out | tdata: seconds, year, month, day, weekday, hour, minute, second
//
//  Date to seconds: a 12-bit serial multiply-accumulate of the year by 365, then
//  three mixed-radix time digits, one per cycle.
//  Seconds to date: the serial divider (one quotient bit a cycle, 33 bits over
//  four divisions), then the year/month walk.
//  One item at a time; s_axis_tready is high only when idle.
//  The output register holds a finished result while m_axis_tready is low; the
//  next item is accepted meanwhile and waits finished until the register frees.
//  Synchronous active-low reset, no clear pass.
module unix_time_calendar_converter_unit import ucc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [31:0] seconds_in, [43:32] year_in, [47:44] month_in, [52:48] day_in,
    // [57:53] hour_in, [63:58] minute_in, [69:64] second_in, [71:70] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] seconds_out, [43:32] year_out, [47:44] month_out, [52:48] day_out,
    // [55:53] weekday_out, [60:56] hour_out, [66:61] minute_out,
    // [72:67] second_out, [79:73] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    ucc_state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic        op_reg, op_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [11:0] yo_sh_reg, yo_sh_next;
    logic [9:0]  addend_reg, addend_next;
    logic [17:0] time_sh_reg, time_sh_next;

    logic [15:0] days_reg, days_next;
    logic [2:0]  wd_reg, wd_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  cyc_reg, cyc_next;
    logic [10:0] rest_reg, rest_next;
    logic [1:0]  yi_reg, yi_next;
    logic [3:0]  mon_reg, mon_next;

    div_req_t              div_req;
    div_stat_t             div_stat;
    logic [DIV_BITS_W-1:0] div_quot;
    logic [DIV_REM_W-1:0]  div_rem;

    // Input field split
    logic [31:0] in_sec;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_min;
    logic [5:0]  in_secf;

    assign in_sec   = s_axis_tdata[31:0];
    assign in_year  = s_axis_tdata[43:32];
    assign in_month = s_axis_tdata[47:44];
    assign in_day   = s_axis_tdata[52:48];
    assign in_hour  = s_axis_tdata[57:53];
    assign in_min   = s_axis_tdata[63:58];
    assign in_secf  = s_axis_tdata[69:64];

    // Clamp the date and form the years since epoch and the day offset
    logic [11:0] year_c;
    logic [3:0]  month_c;
    logic [4:0]  day_c;
    logic [11:0] years_off;
    logic [11:0] leap_base;
    logic        leap_adj;
    logic [8:0]  doy;

    always_comb begin
        year_c = (in_year < EPOCH_YEAR) ? EPOCH_YEAR : in_year;
        if (in_month == 4'd0) begin
            month_c = 4'd1;
        end else if (in_month > 4'd12) begin
            month_c = 4'd12;
        end else begin
            month_c = in_month;
        end
        day_c     = (in_day == 5'd0) ? 5'd1 : in_day;
        years_off = year_c - EPOCH_YEAR;
        leap_base = year_c - LEAP_BASE_YEAR;
        leap_adj  = (year_c[1:0] == 2'd0) && (month_c > 4'd2);
        doy       = cum_days(month_c - 4'd1) + 9'(leap_adj) + 9'(day_c) - 9'd1;
    end

    // Narrow helpers for the walk and the weekday fold
    logic [3:0]  wd_dbl;
    logic [10:0] year_len;
    logic [10:0] mon_len;
    logic [3:0]  wd_shift;
    logic [2:0]  weekday;
    logic [11:0] year_out;
    logic [31:0] time_mul;

    assign wd_dbl   = {wd_reg, 1'b0} + 4'(div_stat.qbit);
    assign year_len = (yi_reg == LEAP_YEAR_IDX) ? LEAP_YEAR_DAYS : NORM_YEAR_DAYS;
    assign mon_len  = 11'(days_in_month(mon_reg, yi_reg == LEAP_YEAR_IDX));
    // 1970-01-01 was a Thursday: weekday = (days + 3) mod 7
    assign wd_shift = 4'(wd_reg) + 4'd3;
    assign weekday  = (wd_shift >= 4'd7) ? 3'(wd_shift - 4'd7) : wd_shift[2:0];
    assign year_out = EPOCH_YEAR + 12'({cyc_reg, 2'b00}) + 12'(yi_reg);
    // x24 for the hour digit, x60 for minute and second
    assign time_mul = (cnt_reg == 4'd3) ? ((acc_reg << 4) + (acc_reg << 3))
                                        : ((acc_reg << 6) - (acc_reg << 2));

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        yo_sh_next   = yo_sh_reg;
        addend_next  = addend_reg;
        time_sh_next = time_sh_reg;
        days_next    = days_reg;
        wd_next      = wd_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        cyc_next     = cyc_reg;
        rest_next    = rest_reg;
        yi_next      = yi_reg;
        mon_next     = mon_reg;
        div_req      = '0;

        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    op_next = s_axis_tuser;
                    if (s_axis_tuser == OP_DATE_TO_SEC) begin
                        acc_next     = '0;
                        yo_sh_next   = years_off;
                        addend_next  = 10'(leap_base[11:2]) + 10'(doy);
                        time_sh_next = {1'b0, in_hour, in_min, in_secf};
                        cnt_next     = 4'd12;
                        state_next   = ST_YEAR_MAC;
                    end else begin
                        // Top 16 bits are below 86400, so they seed the remainder
                        div_req.start    = 1'b1;
                        div_req.rem_init = {1'b0, in_sec[31:16]};
                        div_req.bits     = in_sec[15:0];
                        div_req.divisor  = SECS_PER_DAY;
                        div_req.count    = DIV_CNT_W'(16);
                        wd_next          = '0;
                        state_next       = ST_DIV_DAY;
                    end
                end
            end

            // days = 365 * years + leap days + day of year, MSB first
            ST_YEAR_MAC: begin
                acc_next = (acc_reg << 1) + (yo_sh_reg[11] ? DAYS_PER_YEAR : 32'd0)
                         + ((cnt_reg == 4'd1) ? 32'(addend_reg) : 32'd0);
                yo_sh_next = {yo_sh_reg[10:0], 1'b0};
                cnt_next   = cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    cnt_next   = 4'd3;
                    state_next = ST_TIME_MAC;
                end
            end

            // Mixed radix: ((days*24 + h)*60 + m)*60 + s, wraps at 32 bits
            ST_TIME_MAC: begin
                acc_next     = time_mul + 32'(time_sh_reg[17:12]);
                time_sh_next = {time_sh_reg[11:0], 6'd0};
                cnt_next     = cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    state_next = ST_DONE;
                end
            end

            // Quotient bits also fold into days mod 7
            ST_DIV_DAY: begin
                if (div_stat.qbit_valid) begin
                    wd_next = (wd_dbl >= 4'd7) ? 3'(wd_dbl - 4'd7) : wd_dbl[2:0];
                end
                if (div_stat.done) begin
                    days_next        = div_quot;
                    div_req.start    = 1'b1;
                    div_req.rem_init = {5'd0, div_rem[16:5]};
                    div_req.bits     = {div_rem[4:0], 11'd0};
                    div_req.divisor  = SECS_PER_HOUR;
                    div_req.count    = DIV_CNT_W'(5);
                    state_next       = ST_DIV_HOUR;
                end
            end

            ST_DIV_HOUR: begin
                if (div_stat.done) begin
                    hour_next        = div_quot[4:0];
                    div_req.start    = 1'b1;
                    div_req.rem_init = {11'd0, div_rem[11:6]};
                    div_req.bits     = {div_rem[5:0], 10'd0};
                    div_req.divisor  = SECS_PER_MIN;
                    div_req.count    = DIV_CNT_W'(6);
                    state_next       = ST_DIV_MIN;
                end
            end

            ST_DIV_MIN: begin
                if (div_stat.done) begin
                    min_next         = div_quot[5:0];
                    sec_next         = div_rem[5:0];
                    div_req.start    = 1'b1;
                    div_req.rem_init = {7'd0, days_reg[15:6]};
                    div_req.bits     = {days_reg[5:0], 10'd0};
                    div_req.divisor  = DAYS_PER_CYCLE;
                    div_req.count    = DIV_CNT_W'(6);
                    state_next       = ST_DIV_CYC;
                end
            end

            ST_DIV_CYC: begin
                if (div_stat.done) begin
                    cyc_next   = div_quot[5:0];
                    rest_next  = div_rem[10:0];
                    yi_next    = '0;
                    state_next = ST_WALK_YEAR;
                end
            end

            // Whole years of the four-year cycle, third one leap
            ST_WALK_YEAR: begin
                if ((yi_reg != LAST_YEAR_IDX) && (rest_reg >= year_len)) begin
                    rest_next = rest_reg - year_len;
                    yi_next   = yi_reg + 2'd1;
                end else begin
                    mon_next   = '0;
                    state_next = ST_WALK_MONTH;
                end
            end

            ST_WALK_MONTH: begin
                if ((mon_reg != LAST_MONTH_IDX) && (rest_reg >= mon_len)) begin
                    rest_next = rest_reg - mon_len;
                    mon_next  = mon_reg + 4'd1;
                end else begin
                    state_next = ST_DONE;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    if (op_reg == OP_DATE_TO_SEC) begin
                        m_data_next = {48'd0, acc_reg};
                    end else begin
                        m_data_next = {7'd0, sec_reg, min_reg, hour_reg, weekday,
                                       5'(rest_reg) + 5'd1, mon_reg + 4'd1,
                                       year_out, 32'd0};
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Working and result registers
    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        op_reg      <= op_next;
        acc_reg     <= acc_next;
        yo_sh_reg   <= yo_sh_next;
        addend_reg  <= addend_next;
        time_sh_reg <= time_sh_next;
        days_reg    <= days_next;
        wd_reg      <= wd_next;
        hour_reg    <= hour_next;
        min_reg     <= min_next;
        sec_reg     <= sec_next;
        cyc_reg     <= cyc_next;
        rest_reg    <= rest_next;
        yi_reg      <= yi_next;
        mon_reg     <= mon_next;
    end

    ucc_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

/* hdl/ucc_serial_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, constant-sized operands.
module ucc_serial_div import ucc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  div_req_t              req,
    output div_stat_t             stat,
    output logic [DIV_BITS_W-1:0] quot,
    output logic [DIV_REM_W-1:0]  rem
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_REM_W-1:0]  rem_reg, rem_next;
    logic [DIV_BITS_W-1:0] bits_reg, bits_next;
    logic [DIV_BITS_W-1:0] quot_reg, quot_next;
    logic [DIV_REM_W-1:0]  divisor_reg, divisor_next;

    logic [DIV_REM_W:0]    trial;
    logic [DIV_REM_W:0]    diff;
    logic                  ge;

    // One trial subtraction per cycle
    assign trial = {rem_reg, bits_reg[DIV_BITS_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign ge    = (trial >= {1'b0, divisor_reg});

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        bits_next    = bits_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            cnt_next     = req.count;
            rem_next     = req.rem_init;
            bits_next    = req.bits;
            quot_next    = '0;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
            bits_next = {bits_reg[DIV_BITS_W-2:0], 1'b0};
            quot_next = {quot_reg[DIV_BITS_W-2:0], ge};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        bits_reg    <= bits_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy       = busy_reg;
    assign stat.done       = done_reg;
    assign stat.qbit_valid = busy_reg;
    assign stat.qbit       = ge;
    assign quot            = quot_reg;
    assign rem             = rem_reg;

endmodule

/* hdl/ucc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the converter, bound onto the top level.
module ucc_checker import ucc_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result transfer holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One item in flight: accepting busies the input side
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // A date result has its fields in range and no seconds value
    a_date_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[47:44] != 4'd0) |->
            (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[43:32] >= EPOCH_YEAR) &&
            (m_axis_tdata[47:44] <= 4'd12) && (m_axis_tdata[52:48] != 5'd0) &&
            (m_axis_tdata[55:53] <= 3'd6) && (m_axis_tdata[60:56] <= 5'd23) &&
            (m_axis_tdata[66:61] <= 6'd59) && (m_axis_tdata[72:67] <= 6'd59))
        else $error("date result out of range");

    // A seconds result carries nothing above the seconds field
    a_secs_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[47:44] == 4'd0) |->
            (m_axis_tdata[M_TDATA_W-1:32] == '0))
        else $error("seconds result has stray date bits");

endmodule

bind unix_time_calendar_converter_unit ucc_checker u_ucc_checker (.*);

/* sim/calendar_conversion_checker.sv */
`timescale 1ns / 1ps
// Watches both stream channels of the converter, predicts each result and compares it.
module calendar_conversion_checker import ucc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    output int                   mismatches,
    output int                   pending,
    output int                   n_checked
);

    // Result layout, lowest field last so it lands in the low bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [31:0] seconds;
    } conv_result_t;

    conv_result_t expected_conversions[$];
    conv_result_t want;
    conv_result_t got;

    initial begin
        mismatches = 0;
        pending    = 0;
        n_checked  = 0;
    end

    // Days in a month (index 0..11); February gets 29 when leap is set
    function automatic int month_len(int idx, bit leap);
        case (idx)
            1:           return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:     return 31;
        endcase
    endfunction

    // Expected result for one input transfer
    function automatic conv_result_t predict_conversion(logic op, logic [S_TDATA_W-1:0] d);
        conv_result_t r;
        longint unsigned yr, mo, dy, yy, days, total;
        longint unsigned ut, day_cnt, cyc, rest, m, tmp;
        int i;
        r = '0;
        if (op == OP_DATE_TO_SEC) begin
            yr = 64'(d[43:32]);
            mo = 64'(d[47:44]);
            dy = 64'(d[52:48]);
            // clamp year, month and day; time fields go in as they are
            if (yr < 1970) yr = 1970;
            if (mo < 1) mo = 1;
            if (mo > 12) mo = 12;
            if (dy < 1) dy = 1;
            yy = yr - 1900;
            days = 0;
            for (i = 0; i < mo - 1; i++) days += month_len(i, (yy % 4) == 0);
            // leap days before the year: floor((yy-77)/4) + 2
            total = 365 * (yy - 70) + (yy - 69) / 4 + days + dy - 1;
            total = total * 86400 + 3600 * longint'(d[57:53]) + 60 * longint'(d[63:58])
                  + longint'(d[69:64]);
            r.seconds = total[31:0];
        end else begin
            ut      = 64'(d[31:0]);
            day_cnt = ut / 86400;
            cyc     = day_cnt / 1461;
            rest    = day_cnt % 1461;
            m       = 0;
            // walk the 48 months of a four-year cycle; month 25 is the leap February
            while (m < 47 && rest >= month_len(int'(m % 12), m == 25)) begin
                rest -= month_len(int'(m % 12), m == 25);
                m++;
            end
            tmp       = 4 * cyc + m / 12 + 1970;
            r.year    = tmp[11:0];
            tmp       = m % 12 + 1;
            r.month   = tmp[3:0];
            tmp       = rest + 1;
            r.day     = tmp[4:0];
            tmp       = (day_cnt + 3) % 7;    // epoch day was a Thursday
            r.weekday = tmp[2:0];
            tmp       = (ut % 86400) / 3600;
            r.hour    = tmp[4:0];
            tmp       = (ut % 3600) / 60;
            r.minute  = tmp[5:0];
            tmp       = ut % 60;
            r.second  = tmp[5:0];
        end
        return r;
    endfunction

    task automatic report_field(string name, longint unsigned exp_val, longint unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Compare result transfers first, then queue the prediction for an input transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_conversions.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_conversions.pop_front();
                    report_field("seconds", want.seconds, got.seconds);
                    report_field("year",    want.year,    got.year);
                    report_field("month",   want.month,   got.month);
                    report_field("day",     want.day,     got.day);
                    report_field("weekday", want.weekday, got.weekday);
                    report_field("hour",    want.hour,    got.hour);
                    report_field("minute",  want.minute,  got.minute);
                    report_field("second",  want.second,  got.second);
                    report_field("padding", want.pad,     got.pad);
                    n_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_conversions.push_back(predict_conversion(s_axis_tuser, s_axis_tdata));
        end
        pending <= expected_conversions.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, stimulus, flow control and verdict.
module testbench import ucc_pkg::*;;

    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 135;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = OP_DATE_TO_SEC;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int pending;
    int n_checked;
    int src_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_hold = 1'b0;
    int n_to_secs = 0;
    int n_to_date = 0;

    unix_time_calendar_converter_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    calendar_conversion_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .n_checked     (n_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random stalls, or one long hold when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                rx_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Offer one item after a random idle gap and wait for its transfer
    task automatic send_item(input logic op, input logic [31:0] secs, input logic [11:0] yr,
                             input logic [3:0] mo, input logic [4:0] dy, input logic [4:0] hh,
                             input logic [5:0] mm, input logic [5:0] ss);
        if (op == OP_DATE_TO_SEC) n_to_secs++;
        else n_to_date++;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, ss, mm, hh, dy, mo, yr, secs};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Random item; unused fields carry junk, conversions lean toward plausible ranges
    task automatic send_random();
        logic        op;
        logic [31:0] secs;
        logic [11:0] yr;
        logic [4:0]  hh;
        logic [5:0]  mm, ss;
        op   = 1'($urandom_range(0, 1));
        secs = $urandom;
        if (op == OP_SEC_TO_DATE && $urandom_range(0, 3) == 0)
            secs = $urandom_range(0, 49710) * 86400 + $urandom_range(0, 2) - 1;
        yr = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                         : 12'($urandom_range(1960, 2110));
        hh = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
        mm = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
        ss = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
        send_item(op, secs, yr, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                  hh, mm, ss);
    endtask

    // Stop offering and wait until every predicted result has been consumed
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: clamping, leap handling, wrap, and seconds boundaries
        send_item(OP_DATE_TO_SEC, $urandom, 12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd0);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd1969, 4'd15, 5'd31, 5'd23, 6'd59, 6'd59);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd1972, 4'd2,  5'd29, 5'd12, 6'd0,  6'd0);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd1972, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd1971, 4'd13, 5'd31, 5'd0,  6'd0,  6'd0);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd1973, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd1976, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd2000, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd2100, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd2106, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
        send_item(OP_DATE_TO_SEC, $urandom, 12'd2024, 4'd6,  5'd15, 5'd31, 6'd63, 6'd63);
        send_item(OP_SEC_TO_DATE, 32'd0,          '1, '1, '1, '1, '1, '1);
        send_item(OP_SEC_TO_DATE, 32'd86399,      '0, '0, '0, '0, '0, '0);
        send_item(OP_SEC_TO_DATE, 32'd86400,      '1, '1, '1, '1, '1, '1);
        send_item(OP_SEC_TO_DATE, 32'd68169599,   '0, '0, '0, '0, '0, '0);
        send_item(OP_SEC_TO_DATE, 32'd68169600,   '1, '1, '1, '1, '1, '1);
        send_item(OP_SEC_TO_DATE, 32'd68256000,   '0, '0, '0, '0, '0, '0);
        send_item(OP_SEC_TO_DATE, 32'd126230399,  '1, '1, '1, '1, '1, '1);
        send_item(OP_SEC_TO_DATE, 32'd126230400,  '0, '0, '0, '0, '0, '0);
        send_item(OP_SEC_TO_DATE, 32'd951782400,  '1, '1, '1, '1, '1, '1);
        send_item(OP_SEC_TO_DATE, 32'h7FFF_FFFF,  '0, '0, '0, '0, '0, '0);
        send_item(OP_SEC_TO_DATE, 32'hFFFF_FFFF,  '1, '1, '1, '1, '1, '1);

        // Sender pauses until everything is out, then the output is held
        // while items keep coming so the input stalls
        wait_drained();
        rx_hold = 1'b1;
        repeat (8) send_random();

        // Random phases under different flow-control mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin src_idle_pct = 63; rx_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  rx_stall_pct = 63; end
                default: begin src_idle_pct = 13; rx_stall_pct = 13; end
            endcase
            repeat (RANDOM_ITEMS) send_random();
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then leave time for any stray result
        wait_drained();
        repeat (60) @(posedge aclk);

        $display("summary: %0d date-to-seconds and %0d seconds-to-date transfers,",
                 n_to_secs, n_to_date);
        $display("summary: %0d results checked; clamped and wrapped dates, leap boundaries,",
                 n_checked);
        $display("summary: long output hold and four stall mixes");
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
